// ===== src/arh_pkg.sv =====
// Shared constants and types for the auto-range histogram.
package arh_pkg;
	localparam int MaxSamples = 1024;
	localparam int MaxBins = 64;
	localparam int SampleBits = 16;
	localparam int AddrW = $clog2(MaxSamples);
	localparam int TallyW = $clog2(MaxSamples + 1);
	localparam int BinW = $clog2(MaxBins);
	localparam int BinsW = $clog2(MaxBins + 1);
	localparam int HitsW = 11;
	localparam int CentreW = 24;
	localparam int RangeW = SampleBits + 1;
	localparam logic [HitsW-1:0] HitsMax = '1;
	localparam logic [6:0] BinTotalReset = 7'd16;

	typedef enum logic [5:0] {
		ST_LOAD  = 6'b000001,
		ST_CLEAR = 6'b000010,
		ST_BIN   = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_CNT   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic start;
		logic [RangeW+BinsW-1:0] num;
		logic [RangeW-1:0] den;
	} div_req_t;
endpackage

// ===== src/arh_div.sv =====
// Restoring divider, one quotient bit per cycle.
module arh_div (
	input  logic clk,
	input  logic arst_n,
	input  arh_pkg::div_req_t req,
	output logic done,
	output logic [arh_pkg::RangeW+arh_pkg::BinsW-1:0] quot
);
	import arh_pkg::*;
	localparam int NW = RangeW + BinsW;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q, quot_q;
	logic [RangeW-1:0] den_q;
	logic [RangeW:0] rem_q, trial;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;

	assign trial = {rem_q[RangeW-1:0], num_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quot_q <= {quot_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quot_q <= {quot_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

// ===== src/auto_range_histogram.sv =====
// Top level of the auto-range histogram.
// Usage:
//  Samples stream in on s_axis (tdata = sample, tlast = last of the set) and
//  are taken one per cycle while loading; min and max are tracked on the fly.
//  A transaction with tlast closes the set. Input is then held off while the
//  block clears the count memory, bins every stored sample (per sample: a
//  store read, a 24-step serial divide and a count read-modify-write; a
//  sample that needs no divide skips the divide), then emits one result per
//  bin on m_axis. For each bin the block loads the centre divide, runs 32
//  divide steps and registers the result. bin_total on the cfg channel is
//  sampled when a set closes. At reset the tally, drop flag and state
//  clear; count memory is cleared at the start of each binning pass, sample
//  memory needs no reset. A stall on m_axis holds the result register and
//  the next bin waits behind it; nothing is lost.
//  Samples past the store capacity are dropped and flagged in every result.
module auto_range_histogram (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sample
	input  logic s_axis_tlast,          // last_sample
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [5:0] bin_index, [16:6] bin_hits, [40:17] bin_centre_q8,
	                                    // [41] overflowed, [47:42] zero
	output logic m_axis_tlast,          // last_bin
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [6:0] cfg_data         // bin_total
);
	import arh_pkg::*;
	localparam int NW = RangeW + BinsW;

	state_t state_q;
	logic [6:0] bin_total_q;
	logic [TallyW-1:0] tally_q;
	logic [AddrW-1:0] idx_q;
	logic [BinsW-1:0] bins_q;
	logic [BinW-1:0] bin_q;
	logic signed [SampleBits-1:0] min_q, max_q, x_s1;
	logic rv_q, drop_q, rd_s1, wait_q;
	logic [RangeW-1:0] range_q;

	// memories
	logic signed [SampleBits-1:0] smem [MaxSamples];
	logic [HitsW-1:0] cmem [MaxBins];
	logic [HitsW-1:0] cnt_rd_s1;

	div_req_t dreq;
	logic ddone;
	logic [NW-1:0] dquot;

	arh_div u_div (.clk, .arst_n, .req(dreq), .done(ddone), .quot(dquot));

	logic s_acc, m_free;
	assign s_axis_tready = (state_q == ST_LOAD);
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign m_free = !m_axis_tvalid || m_axis_tready;

	logic signed [SampleBits-1:0] sx;
	assign sx = s_axis_tdata;
	logic store_ok;
	assign store_ok = (tally_q < TallyW'(MaxSamples));

	// effective bin count at close
	logic [BinsW-1:0] bins_eff;
	always_comb begin
		if (bin_total_q == 7'd0) bins_eff = BinsW'(1);
		else if ({25'd0, bin_total_q} > MaxBins) bins_eff = BinsW'(MaxBins);
		else bins_eff = BinsW'(bin_total_q);
	end
	logic [RangeW-1:0] range_now;
	assign range_now = RangeW'(signed'({max_q[SampleBits-1], max_q})
		- signed'({min_q[SampleBits-1], min_q}));
	logic [RangeW-1:0] off_s1;
	assign off_s1 = RangeW'(signed'({x_s1[SampleBits-1], x_s1})
		- signed'({min_q[SampleBits-1], min_q}));

	// binning target from sample stage or divider
	logic [BinW-1:0] tgt_q;
	logic [BinW-1:0] last_b;
	assign last_b = BinW'(bins_q - 1'b1);

	// centre: (2i+1)*range*256/(2*bins) = (2i+1)*range*128/bins
	logic [NW-1:0] odd_i;
	assign odd_i = NW'({bin_q, 1'b1});
	logic [31:0] cprod;
	assign cprod = 32'(odd_i) * 32'(range_q);

	always_comb begin
		dreq = '0;
		if (state_q == ST_BIN && rd_s1 && !(range_q == '0 || x_s1 >= max_q)) begin
			dreq.start = 1'b1;
			dreq.num = NW'(off_s1) * NW'(bins_q);
			dreq.den = range_q;
		end
	end

	// centre numerator (2i+1)*range*128 fits 31 bits; 32-step serial divide by bins
	logic [31:0] cnum_q;
	logic [5:0] cstep_q;
	logic [31:0] crem_q, cquo_q, ctrial;
	assign ctrial = {crem_q[30:0], cnum_q[31]};
	logic cbusy_q;

	// result register loads when the centre is ready and the output is free
	logic emit_go;
	assign emit_go = (state_q == ST_EMIT) && !cbusy_q && rd_s1 && m_free;

	logic signed [33:0] centre_full;
	logic signed [CentreW-1:0] centre_sat;
	always_comb begin
		centre_full = 34'(signed'({min_q[SampleBits-1], min_q})) * 34'sd256
			+ signed'({2'b00, cquo_q});
		if (centre_full > 34'sd8388607) centre_sat = 24'h7FFFFF;
		else if (centre_full < -34'sd8388608) centre_sat = 24'h800000;
		else centre_sat = centre_full[CentreW-1:0];
	end

	always_ff @(posedge clk) begin
		if (s_acc && store_ok) smem[idx_q] <= sx;
		if (state_q == ST_BIN) x_s1 <= smem[idx_q];
		cnt_rd_s1 <= cmem[tgt_q];
		if (state_q == ST_CLEAR) cmem[bin_q] <= '0;
		else if (state_q == ST_CNT && wait_q && cnt_rd_s1 != HitsMax)
			cmem[tgt_q] <= cnt_rd_s1 + 1'b1;
		if (state_q == ST_EMIT && !cbusy_q && m_free && rd_s1) begin
			m_axis_tdata <= {6'd0, drop_q, centre_sat, cnt_rd_s1, bin_q};
			m_axis_tlast <= (bin_q == last_b);
		end
		if (cbusy_q) begin
			cnum_q <= {cnum_q[30:0], 1'b0};
			if (ctrial >= 32'(bins_q)) begin
				crem_q <= ctrial - 32'(bins_q);
				cquo_q <= {cquo_q[30:0], 1'b1};
			end else begin
				crem_q <= ctrial;
				cquo_q <= {cquo_q[30:0], 1'b0};
			end
		end else if (state_q == ST_EMIT && !rd_s1) begin
			cnum_q <= {cprod[24:0], 7'd0};
			crem_q <= '0;
			cquo_q <= '0;
		end
		if (ddone) tgt_q <= (dquot >= NW'(bins_q)) ? last_b : dquot[BinW-1:0];
		else if (state_q == ST_BIN && rd_s1 && !dreq.start) tgt_q <= last_b;
		else if (state_q == ST_EMIT && !rd_s1) tgt_q <= bin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			bin_total_q <= BinTotalReset;
			tally_q <= '0;
			idx_q <= '0;
			rv_q <= 1'b0;
			drop_q <= 1'b0;
			min_q <= '0;
			max_q <= '0;
			bins_q <= BinsW'(1);
			bin_q <= '0;
			range_q <= '0;
			rd_s1 <= 1'b0;
			wait_q <= 1'b0;
			cbusy_q <= 1'b0;
			cstep_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) bin_total_q <= cfg_data;
			if (emit_go) m_axis_tvalid <= 1'b1;
			else if (m_axis_tready) m_axis_tvalid <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						if (store_ok) begin
							idx_q <= idx_q + 1'b1;
							tally_q <= tally_q + 1'b1;
							if (!rv_q || sx < min_q) min_q <= sx;
							if (!rv_q || sx > max_q) max_q <= sx;
							rv_q <= 1'b1;
						end else drop_q <= 1'b1;
						if (s_axis_tlast) begin
							bins_q <= bins_eff;
							bin_q <= '0;
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_CLEAR: begin
					range_q <= rv_q ? range_now : '0;
					if (!rv_q) begin
						min_q <= '0;
						max_q <= '0;
					end
					if (bin_q == last_b) begin
						bin_q <= '0;
						idx_q <= '0;
						rd_s1 <= 1'b0;
						state_q <= (tally_q == '0) ? ST_EMIT : ST_BIN;
					end else bin_q <= bin_q + 1'b1;
				end
				ST_BIN: begin
					// read issued first; then data in x_s1, decide
					if (!rd_s1) rd_s1 <= 1'b1;
					else begin
						rd_s1 <= 1'b0;
						state_q <= dreq.start ? ST_DIV : ST_CNT;
						wait_q <= 1'b0;
					end
				end
				ST_DIV: if (ddone) begin
					state_q <= ST_CNT;
					wait_q <= 1'b0;
				end
				ST_CNT: begin
					// count read first, then write back
					if (!wait_q) wait_q <= 1'b1;
					else begin
						wait_q <= 1'b0;
						if ({1'b0, idx_q} == TallyW'(tally_q - 1'b1)) begin
							idx_q <= '0;
							bin_q <= '0;
							rd_s1 <= 1'b0;
							state_q <= ST_EMIT;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_BIN;
						end
					end
				end
				ST_EMIT: begin
					if (!rd_s1 && !cbusy_q) begin
						cbusy_q <= 1'b1;
						cstep_q <= 6'd32;
					end else if (cbusy_q) begin
						cstep_q <= cstep_q - 1'b1;
						if (cstep_q == 6'd1) begin
							cbusy_q <= 1'b0;
							rd_s1 <= 1'b1;
						end
					end else if (m_free) begin
						rd_s1 <= 1'b0;
						if (bin_q == last_b) begin
							tally_q <= '0;
							idx_q <= '0;
							rv_q <= 1'b0;
							drop_q <= 1'b0;
							state_q <= ST_LOAD;
						end else bin_q <= bin_q + 1'b1;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

// ===== sim/auto_range_histogram_tb.sv =====
// Testbench for the auto-range histogram: directed and random sets against a scoreboard model.
module auto_range_histogram_tb;
	import arh_pkg::*;

	// one expected or observed bin result
	typedef struct packed {
		logic [5:0]  idx;
		logic [10:0] hits;
		logic [23:0] centre;
		logic        ovf;
		logic        lastb;
	} bin_res_t;

	// Histogram scoreboard: keeps the loading set and the queue of pending bins.
	class hist_board;
		logic signed [15:0] set_vals[$];
		logic signed [15:0] lo, hi;
		bit dropped;
		int unsigned bins_reg;
		bin_res_t pending[$];
		int errors;

		function new();
			bins_reg = BinTotalReset;
			errors = 0;
			dropped = 0;
		endfunction

		function void note_sample(logic signed [15:0] x, bit lst);
			int unsigned nb;
			longint rng, c, off;
			int unsigned cnt[64];
			int unsigned b;
			bin_res_t r;
			if (set_vals.size() < MaxSamples) begin
				if (set_vals.size() == 0) begin
					lo = x;
					hi = x;
				end else begin
					if (x < lo) lo = x;
					if (x > hi) hi = x;
				end
				set_vals.insert(set_vals.size(), x);
			end else
				dropped = 1;
			if (!lst) return;
			nb = bins_reg < 1 ? 1 : (bins_reg > MaxBins ? MaxBins : bins_reg);
			rng = longint'(hi) - longint'(lo);
			for (int i = 0; i < 64; i++) cnt[i] = 0;
			foreach (set_vals[k]) begin
				if (rng <= 0 || set_vals[k] >= hi)
					b = nb - 1;
				else begin
					off = longint'(set_vals[k]) - longint'(lo);
					b = 32'((off * nb) / rng);
					if (b >= nb) b = nb - 1;
				end
				if (cnt[b] < 2047) cnt[b]++;
			end
			for (int i = 0; i < nb; i++) begin
				c = longint'(lo) * 256
					+ (longint'(2 * i + 1) * rng * 256) / (longint'(nb) * 2);
				if (c > 8388607) c = 8388607;
				if (c < -8388608) c = -8388608;
				r.idx = 6'(i);
				r.hits = 11'(cnt[i]);
				r.centre = c[23:0];
				r.ovf = dropped;
				r.lastb = (i == nb - 1);
				pending.insert(pending.size(), r);
			end
			set_vals.delete();
			dropped = 0;
		endfunction

		function void check_bin(bin_res_t got);
			bin_res_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected bin result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display({"bin mismatch: exp idx %0d hits %0d ctr %h ovf %b last %b,",
						" got idx %0d hits %0d ctr %h ovf %b last %b"},
						want.idx, want.hits, want.centre, want.ovf, want.lastb,
						got.idx, got.hits, got.centre, got.ovf, got.lastb);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
	logic [15:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
	logic [47:0] m_axis_tdata;
	logic cfg_valid, cfg_ready;
	logic [6:0] cfg_data;

	hist_board board;
	longint cycles = 0;

	auto_range_histogram dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 94) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// watchdog, plus output-side checking on each rising edge
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("auto_range_histogram_tb failed");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_bin({m_axis_tdata[5:0], m_axis_tdata[16:6], m_axis_tdata[40:17],
				m_axis_tdata[41], m_axis_tlast});
	end

	// receiver: random stalls
	initial begin
		int g;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			g = gap_len();
			if (g == 0) m_axis_tready = 1;
			else begin
				m_axis_tready = 0;
				repeat (g) @(negedge clk);
				m_axis_tready = 1;
			end
		end
	end

	task automatic push_sample(logic [15:0] v, bit lst);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid = 0;
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid = 1;
		s_axis_tdata = v;
		s_axis_tlast = lst;
		do @(posedge clk); while (!s_axis_tready);
		board.note_sample(v, lst);
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	// write bin_total only when nothing is pending
	task automatic write_bins(logic [6:0] v);
		while (board.pending.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		cfg_valid = 1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		board.bins_reg = v;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic send_set(int n, int mode);
		logic [15:0] v;
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: v = 16'($urandom);
				1: v = 16'($urandom_range(0, 40) - 20);
				default: v = 16'h1234;
			endcase
			push_sample(v, i == n - 1);
		end
	endtask

	initial begin
		int n;
		board = new();
		n = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tlast = 0;
		cfg_valid = 0;
		cfg_data = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, single-sample set, equal samples, default bins
		push_sample(16'h8000, 0);
		push_sample(16'h7fff, 0);
		push_sample(16'h0000, 0);
		push_sample(16'hffff, 1);
		push_sample(16'h0005, 1);                 // zero range
		write_bins(7'd0);                         // clamped to one bin
		send_set(3, 0);
		write_bins(7'd127);                       // clamped to max bins
		send_set(5, 0);
		write_bins(7'd64);
		push_sample(16'h8000, 0);
		push_sample(16'h7fff, 1);
		write_bins(7'd1);
		send_set(4, 2);                           // all equal
		write_bins(7'd8);

		// random sets, mostly small with few bins
		while (n < 230) begin
			int k;
			if ($urandom_range(0, 3) == 0)
				write_bins(7'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 8)));
			k = $urandom_range(1, 12);
			send_set(k, $urandom_range(0, 2));
			n += k;
		end

		while (board.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (board.errors == 0)
			$display("auto_range_histogram_tb passed");
		else
			$display("auto_range_histogram_tb failed");
		$finish;
	end
endmodule
